### rtl/ritoa_pkg.sv
// Shared types, command codes and constants for the radix integer to ASCII converter.
`default_nettype none

package ritoa_pkg;

    localparam logic [1:0] CMD_OCT       = 2'd0;
    localparam logic [1:0] CMD_DEC       = 2'd1;
    localparam logic [1:0] CMD_HEX_LOWER = 2'd2;
    localparam logic [1:0] CMD_HEX_UPPER = 2'd3;

    localparam int unsigned MAX_DIGITS  = 11;
    localparam int unsigned CNT_W       = 4;
    localparam int unsigned DIGIT_W     = 4;
    localparam int unsigned VALUE_W     = 32;
    localparam int unsigned PROD_W      = 2 * VALUE_W;
    localparam int unsigned RECIP_SHIFT = 35;

    localparam logic [VALUE_W-1:0] RECIP_TEN = 32'hCCCC_CCCD;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_LOWER = 8'h61 - 8'd10;
    localparam logic [7:0] CHAR_UPPER = 8'h41 - 8'd10;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [VALUE_W-1:0] value;
    } in_beat_t;

    typedef struct packed {
        logic [7:0]       character;
        logic             last;
        logic [CNT_W-1:0] digit_count;
    } out_beat_t;

    function automatic logic [7:0] digit_char(input logic [DIGIT_W-1:0] digit,
                                              input logic upper);
        logic [7:0] base;
        begin
            if (digit < 4'd10)
            begin
                base = CHAR_ZERO;
            end
            else if (upper)
            begin
                base = CHAR_UPPER;
            end
            else
            begin
                base = CHAR_LOWER;
            end
            digit_char = base + {4'd0, digit};
        end
    endfunction

endpackage

`default_nettype wire

### rtl/ritoa_div_unit.sv
// Shared divide-by-radix step: quotient and remainder for octal, decimal or hex.
`default_nettype none

module ritoa_div_unit
    import ritoa_pkg::*;
(
    input  wire logic [1:0]         cmd,
    input  wire logic [VALUE_W-1:0] value,
    input  wire logic [PROD_W-1:0]  product,
    output logic      [VALUE_W-1:0] quotient,
    output logic      [DIGIT_W-1:0] remainder
);

    logic [VALUE_W-1:0] dec_q;
    logic [VALUE_W-1:0] dec_tens;
    logic [VALUE_W-1:0] dec_diff;

    assign dec_q    = {{(VALUE_W - (PROD_W - RECIP_SHIFT)){1'b0}},
                       product[PROD_W-1:RECIP_SHIFT]};
    assign dec_tens = (dec_q << 3) + (dec_q << 1);
    assign dec_diff = value - dec_tens;

    always_comb
    begin
        unique case (cmd) inside
            CMD_OCT:
            begin
                quotient  = value >> 3;
                remainder = {1'b0, value[2:0]};
            end
            CMD_DEC:
            begin
                quotient  = dec_q;
                remainder = dec_diff[DIGIT_W-1:0];
            end
            CMD_HEX_LOWER, CMD_HEX_UPPER:
            begin
                quotient  = value >> 4;
                remainder = value[DIGIT_W-1:0];
            end
            default:
            begin
                quotient  = value;
                remainder = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/radix_integer_to_ascii.sv
// Top level of the radix integer to ASCII converter.
// Takes one 32-bit unsigned value with a radix command and emits its digit characters,
// most significant first, one output beat per character; the final beat carries last
// and the character count. After a value is accepted, its digits are produced one at a
// time by the single shared divide step, directly for octal and hex, or for decimal as a
// reciprocal multiply then a remainder step; the digits are then emitted whenever the
// output register is empty or not stalled. The input stalls from acceptance until the
// last character is loaded into the output register; the next value is taken while
// that last character still waits downstream.
`default_nettype none

module radix_integer_to_ascii
    import ritoa_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_stall,
    input  wire in_beat_t  in_data,
    output logic           out_valid,
    input  wire logic      out_stall,
    output out_beat_t      out_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]         state_reg, state_next;
    logic [1:0]         cmd_reg, cmd_next;
    logic [VALUE_W-1:0] value_reg, value_next;
    logic [PROD_W-1:0]  prod_reg, prod_next;
    logic [DIGIT_W-1:0] stack_reg [MAX_DIGITS];
    logic [DIGIT_W-1:0] stack_next [MAX_DIGITS];
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   left_reg, left_next;
    logic               out_valid_reg, out_valid_next;
    out_beat_t          out_reg, out_next;

    logic [VALUE_W-1:0] quotient;
    logic [DIGIT_W-1:0] remainder;
    logic               out_free;

    ritoa_div_unit u_div (
        .cmd       (cmd_reg),
        .value     (value_reg),
        .product   (prod_reg),
        .quotient  (quotient),
        .remainder (remainder)
    );

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        value_next     = value_reg;
        prod_next      = prod_reg;
        stack_next     = stack_reg;
        count_next     = count_reg;
        left_next      = left_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_next       = out_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next   = in_data.cmd;
                    value_next = in_data.value;
                    count_next = '0;
                    state_next = (in_data.cmd == CMD_DEC) ? ST_MUL : ST_DIV;
                end
            end
            ST_MUL:
            begin
                prod_next  = {{VALUE_W{1'b0}}, value_reg} * {{VALUE_W{1'b0}}, RECIP_TEN};
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                stack_next[0] = remainder;
                for (int i = 1; i < MAX_DIGITS; i++)
                begin
                    stack_next[i] = stack_reg[i-1];
                end
                count_next = count_reg + 1'b1;
                value_next = quotient;
                if ((quotient == '0) || (count_reg == CNT_W'(MAX_DIGITS - 1)))
                begin
                    left_next  = count_reg + 1'b1;
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = (cmd_reg == CMD_DEC) ? ST_MUL : ST_DIV;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next        = 1'b1;
                    out_next.character    = digit_char(stack_reg[0],
                                                       cmd_reg == CMD_HEX_UPPER);
                    out_next.last         = (left_reg == CNT_W'(1));
                    out_next.digit_count  = (left_reg == CNT_W'(1)) ? count_reg : '0;
                    for (int i = 0; i < MAX_DIGITS - 1; i++)
                    begin
                        stack_next[i] = stack_reg[i+1];
                    end
                    left_next = left_reg - 1'b1;
                    if (left_reg == CNT_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        value_reg <= value_next;
        prod_reg  <= prod_next;
        stack_reg <= stack_next;
        count_reg <= count_next;
        left_reg  <= left_next;
        out_reg   <= out_next;
    end

endmodule

`default_nettype wire

### rtl/ritoa_checker.sv
// Port-level checker for the radix integer to ASCII converter, bound to the top level.
`default_nettype none

module ritoa_checker
    import ritoa_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      in_valid,
    input wire logic      in_stall,
    input wire in_beat_t  in_data,
    input wire logic      out_valid,
    input wire logic      out_stall,
    input wire out_beat_t out_data
);

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(in_data))
        else $error("stalled input beat changed");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled output beat changed");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not stalled after accepting a value");

    a_count_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.last && out_data.digit_count != 4'd0
                       && out_data.digit_count <= 4'd11)
                      || (!out_data.last && out_data.digit_count == 4'd0))
        else $error("digit count does not match last flag");

    a_digit_char: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.character >= 8'h30 && out_data.character <= 8'h39)
                      || (out_data.character >= 8'h61 && out_data.character <= 8'h66)
                      || (out_data.character >= 8'h41 && out_data.character <= 8'h46))
        else $error("output beat is not a digit character");

endmodule

bind radix_integer_to_ascii ritoa_checker u_ritoa_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

`default_nettype wire
